// ===== rtl/core/assert_macros.svh =====
// Assertion macros of the PID controller, used by its sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PIDSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PIDSG_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PIDSG_ASSERT(lbl, prop, msg)
`define PIDSG_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/pidsg_pkg.sv =====
// Shared types, constants and arithmetic helpers of the PID controller.
`default_nettype none
package pidsg_pkg;
    localparam int TABLE_ROWS = 8;
    localparam int IDX_W      = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int ROW_CNT_W  = ($clog2(TABLE_ROWS + 1) > 4) ? $clog2(TABLE_ROWS + 1) : 4;
    localparam int ROW_W      = 112;
    localparam int IN_W       = 152;
    localparam int OPB_W      = 19;
    localparam int PROD_W     = 51;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_ROW    = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_MODE   = 3'd0,
        CFG_OLIM   = 3'd1,
        CFG_ILIM   = 3'd2,
        CFG_AWAY   = 3'd3,
        CFG_TOWARD = 3'd4,
        CFG_DEAD   = 3'd5,
        CFG_SCHED  = 3'd6,
        CFG_ROWS   = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_RD, ST_CK, ST_MUL_P, ST_MUL_I, ST_MUL_D,
        ST_SAT_D, ST_CLAMP_I, ST_SUM, ST_LIMIT, ST_SLEW, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_P = 2'd0,
        MUL_I = 2'd1,
        MUL_D = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     accept;
        logic     write_row;
        logic     clear;
        logic     idx_inc;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     set_p;
        logic     set_i;
        logic     set_d;
        logic     clamp_i;
        logic     sum;
        logic     limit;
        logic     zero_next;
        logic     slew;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic incr;
        logic dead;
        logic sched_miss;
        logic hit;
        logic last;
    } status_t;

    function automatic logic signed [31:0] sat52(input logic signed [51:0] v);
        if (v > 52'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -52'sh8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] clamp34(input logic signed [33:0] v,
                                                   input logic [30:0] lim);
        logic signed [33:0] l;
        logic signed [33:0] nl;
        l  = $signed({3'b000, lim});
        nl = -l;
        if (v > l)
            return l[31:0];
        else if (v < nl)
            return nl[31:0];
        else
            return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/pidsg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pidsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/pidsg_ctrl.sv =====
// Sequencer of the PID controller: state machine and output valid.
`default_nettype none
`include "assert_macros.svh"
module pidsg_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    input  wire logic [1:0]       func,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire pidsg_pkg::status_t st,
    output pidsg_pkg::cmd_t       cmd
);
    import pidsg_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && func == FUNC_SAMPLE)
                    state_next = ST_DECIDE;
            ST_DECIDE:
                priority if (st.incr)
                    state_next = ST_RD;
                else if (st.dead)
                    state_next = ST_SLEW;
                else if (st.sched_miss)
                    state_next = ST_CLAMP_I;
                else
                    state_next = ST_RD;
            ST_RD:
                state_next = ST_CK;
            ST_CK:
                priority if (st.hit)
                    state_next = ST_MUL_P;
                else if (st.last)
                    state_next = ST_CLAMP_I;
                else
                    state_next = ST_RD;
            ST_MUL_P:   state_next = ST_MUL_I;
            ST_MUL_I:   state_next = ST_MUL_D;
            ST_MUL_D:   state_next = ST_SAT_D;
            ST_SAT_D:   state_next = st.incr ? ST_SUM : ST_CLAMP_I;
            ST_CLAMP_I: state_next = ST_SUM;
            ST_SUM:     state_next = ST_LIMIT;
            ST_LIMIT:   state_next = ST_SLEW;
            ST_SLEW:    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.mul_sel   = MUL_P;
        cmd.accept    = accept && func == FUNC_SAMPLE;
        cmd.write_row = accept && func == FUNC_ROW;
        cmd.clear     = accept && func == FUNC_CLEAR;
        unique case (state_reg)
            ST_DECIDE:  cmd.zero_next = !st.incr && st.dead;
            ST_CK:      cmd.idx_inc = !st.hit && !st.last;
            ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
            end
            ST_MUL_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_I;
                cmd.set_p   = 1'b1;
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D;
                cmd.set_i   = 1'b1;
            end
            ST_SAT_D:   cmd.set_d = 1'b1;
            ST_CLAMP_I: cmd.clamp_i = 1'b1;
            ST_SUM:     cmd.sum = 1'b1;
            ST_LIMIT:   cmd.limit = 1'b1;
            ST_SLEW:    cmd.slew = 1'b1;
            ST_DONE:    cmd.out_load = out_free;
            default:    ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PIDSG_ASSERT(a_sample_starts, cmd.accept |=> state_reg == ST_DECIDE, "sample not started")
    `PIDSG_ASSERT(a_result_shown, cmd.out_load |=> m_tvalid, "loaded result not shown")
    `PIDSG_ASSERT(a_no_overwrite, (state_reg == ST_DONE && m_tvalid && !m_tready) |=> state_reg == ST_DONE, "result overwritten")
    `PIDSG_NEVER(a_one_func, $countones({cmd.accept, cmd.write_row, cmd.clear}) > 1, "two item kinds at once")
endmodule
`default_nettype wire

// ===== rtl/core/pidsg_dp.sv =====
// Datapath of the PID controller: registers, gain table, multiplier, limits.
`default_nettype none
module pidsg_dp (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [2:0]              cfg_addr,
    input  wire logic [30:0]             cfg_wdata,
    input  wire logic signed [15:0]      setpoint,
    input  wire logic signed [15:0]      feedback,
    input  wire logic [2:0]              row_index,
    input  wire logic [pidsg_pkg::ROW_W-1:0] row_data,
    input  wire pidsg_pkg::cmd_t         cmd,
    output pidsg_pkg::status_t           st,
    output logic signed [31:0]           drive
);
    import pidsg_pkg::*;

    logic              mode_reg, sched_reg;
    logic [30:0]       olim_reg, ilim_reg, away_reg, toward_reg;
    logic [15:0]       dead_reg;
    logic [3:0]        rows_reg;

    logic signed [16:0] e_reg, e1_reg, e2_reg;
    logic signed [17:0] d1_reg;
    logic signed [18:0] d2_reg;
    logic [16:0]        mag_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic signed [31:0] p_reg, i_reg, d_reg, drive_reg, next_reg, out_reg;
    logic signed [33:0] sum_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [ROW_W-1:0]   row_rd;
    logic [ROW_CNT_W-1:0] n_rows;
    logic [ROW_CNT_W-1:0] idx_plus;
    logic signed [16:0] e_new;
    logic signed [31:0] op_a;
    logic signed [OPB_W-1:0] op_b;
    logic signed [51:0] prod_ext;
    logic signed [51:0] i_base;
    logic signed [33:0] sum_base;
    logic signed [31:0] slew_out;
    logic signed [32:0] sdiff, s_away, s_toward;
    logic               row_ok;

    pidsg_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ROWS)) u_table (
        .clk   (clk),
        .we    (cmd.write_row && row_ok),
        .waddr (IDX_W'(row_index)),
        .wdata (row_data),
        .raddr (idx_reg),
        .rdata (row_rd)
    );

    assign row_ok = ROW_CNT_W'(row_index) < ROW_CNT_W'(TABLE_ROWS);
    assign e_new  = 17'(setpoint) - 17'(feedback);
    assign n_rows = (ROW_CNT_W'(rows_reg) > ROW_CNT_W'(TABLE_ROWS)) ?
                    ROW_CNT_W'(TABLE_ROWS) : ROW_CNT_W'(rows_reg);
    assign idx_plus = ROW_CNT_W'(idx_reg) + ROW_CNT_W'(1);

    always_comb
    begin
        st.incr       = mode_reg;
        st.dead       = (dead_reg != 16'd0) && (mag_reg < {1'b0, dead_reg});
        st.sched_miss = sched_reg && (n_rows == '0);
        st.hit        = mode_reg || !sched_reg || ({1'b0, row_rd[15:0]} >= mag_reg);
        st.last       = idx_plus >= n_rows;
    end

    always_comb
    begin
        op_a = $signed(row_rd[47:16]);
        op_b = OPB_W'(e_reg);
        unique case (cmd.mul_sel)
            MUL_P:
            begin
                op_a = $signed(row_rd[47:16]);
                op_b = mode_reg ? OPB_W'(d1_reg) : OPB_W'(e_reg);
            end
            MUL_I:
            begin
                op_a = $signed(row_rd[79:48]);
                op_b = OPB_W'(e_reg);
            end
            MUL_D:
            begin
                op_a = $signed(row_rd[111:80]);
                op_b = mode_reg ? d2_reg : OPB_W'(d1_reg);
            end
            default: ;
        endcase
    end

    assign prod_ext = 52'(prod_reg);
    assign i_base   = mode_reg ? 52'sd0 : 52'(i_reg);
    assign sum_base = mode_reg ? 34'(drive_reg) : 34'sd0;

    // Slew step, measured from the previous drive toward or away from zero.
    always_comb
    begin
        sdiff    = 33'(next_reg) - 33'(drive_reg);
        s_away   = $signed({2'b00, away_reg});
        s_toward = $signed({2'b00, toward_reg});
        slew_out = next_reg;
        if (!drive_reg[31])
        begin
            if (sdiff > s_away)
                slew_out = 32'(33'(drive_reg) + s_away);
            else if (sdiff < -s_toward)
                slew_out = 32'(33'(drive_reg) - s_toward);
        end
        else
        begin
            if (sdiff < -s_away)
                slew_out = 32'(33'(drive_reg) - s_away);
            else if (sdiff > s_toward)
                slew_out = 32'(33'(drive_reg) + s_toward);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            olim_reg   <= '1;
            ilim_reg   <= '1;
            away_reg   <= '1;
            toward_reg <= '1;
            dead_reg   <= '0;
            sched_reg  <= 1'b0;
            rows_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MODE:   mode_reg   <= cfg_wdata[0];
                CFG_OLIM:   olim_reg   <= cfg_wdata;
                CFG_ILIM:   ilim_reg   <= cfg_wdata;
                CFG_AWAY:   away_reg   <= cfg_wdata;
                CFG_TOWARD: toward_reg <= cfg_wdata;
                CFG_DEAD:   dead_reg   <= cfg_wdata[15:0];
                CFG_SCHED:  sched_reg  <= cfg_wdata[0];
                CFG_ROWS:   rows_reg   <= cfg_wdata[3:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg    <= '0;
            e2_reg    <= '0;
            p_reg     <= '0;
            i_reg     <= '0;
            d_reg     <= '0;
            drive_reg <= '0;
        end
        else if (cmd.clear)
        begin
            e1_reg    <= '0;
            e2_reg    <= '0;
            p_reg     <= '0;
            i_reg     <= '0;
            d_reg     <= '0;
            drive_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                e1_reg <= e_new;
                e2_reg <= e1_reg;
            end
            if (cmd.set_p)
                p_reg <= sat52(prod_ext);
            if (cmd.set_i)
                i_reg <= sat52(i_base + prod_ext);
            if (cmd.set_d)
                d_reg <= sat52(prod_ext);
            if (cmd.clamp_i)
                i_reg <= clamp34(34'(i_reg), ilim_reg);
            // In positional mode, the integral is dropped when it pulls against the error.
            if (cmd.limit && !mode_reg &&
                ((i_reg > 0 && e_reg < 0) || (i_reg < 0 && e_reg > 0)))
                i_reg <= '0;
            if (cmd.slew)
                drive_reg <= slew_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            e_reg   <= e_new;
            d1_reg  <= 18'(e_new) - 18'(e1_reg);
            d2_reg  <= 19'(e_new) - (19'(e1_reg) <<< 1) + 19'(e2_reg);
            mag_reg <= e_new[16] ? 17'(-e_new) : 17'(e_new);
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.mul_en)
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        if (cmd.sum)
            sum_reg <= sum_base + 34'(p_reg) + 34'(i_reg) + 34'(d_reg);
        if (cmd.limit)
            next_reg <= clamp34(sum_reg, olim_reg);
        else if (cmd.zero_next)
            next_reg <= '0;
        if (cmd.out_load)
            out_reg <= drive_reg;
    end

    assign drive = out_reg;
endmodule
`default_nettype wire

// ===== rtl/core/pid_controller_slew_gain_schedule.sv =====
// Top level of the PID controller with gain schedule and slew limit.
//
//  channel | dir | beat contents
//  s_*     | in  | tuser: func; tdata: setpoint, feedback, row_index,
//          |     |   row_threshold, row_kp, row_ki, row_kd
//  m_*     | out | tdata: drive
//  cfg_*   | in  | register index and data, one write per enabled clock
//
// A positional sample searches the gain table, runs the shared 32x19 multiplier
// three times, clamps the integral, sums, limits and slews; incremental mode skips
// the clamp, the deadzone jumps to the slew, and an empty schedule or no hit skips
// the multiplies. Row writes and clears finish in the accept cycle. Reset is
// asynchronous and clears all loop state; the gain table holds garbage until
// written. A stalled output holds one finished beat while the next beat is taken.
`default_nettype none
module pid_controller_slew_gain_schedule (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [15:0] setpoint, [31:16] feedback, [34:32] row_index, [50:35] row_threshold,
    // [82:51] row_kp, [114:83] row_ki, [146:115] row_kd, rest zero
    input  wire logic [pidsg_pkg::IN_W-1:0] s_tdata,
    // [1:0] func
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] drive
    output logic [31:0]       m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [30:0]  cfg_wdata
);
    import pidsg_pkg::*;

    cmd_t               cmd;
    status_t            st;
    logic signed [31:0] drive;

    pidsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .func     (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pidsg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .setpoint  ($signed(s_tdata[15:0])),
        .feedback  ($signed(s_tdata[31:16])),
        .row_index (s_tdata[34:32]),
        .row_data  (s_tdata[146:35]),
        .cmd       (cmd),
        .st        (st),
        .drive     (drive)
    );

    assign m_tdata = drive;
endmodule
`default_nettype wire
